// ===== hdl/pfp_pkg.sv =====
// Shared types, constants and helper functions of the pulldown field-pairing controller.
package pfp_pkg;

  // Width of the internal saturating counters and of the visible counter fields.
  localparam int COUNT_BITS = 32;
  localparam int OUT_COUNT_BITS = 32;
  localparam int BAL_BITS = 4;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [OUT_COUNT_BITS-1:0] out_count_t;
  typedef logic signed [BAL_BITS-1:0] balance_t;
  typedef logic [1:0] mode_t;
  typedef logic [1:0] code_t;
  typedef logic [2:0] emit_t;

  // Output mode register codes; the unused code behaves as normal.
  localparam mode_t MODE_NORMAL = 2'd0;
  localparam mode_t MODE_FILM = 2'd1;
  localparam mode_t MODE_RAW = 2'd2;

  // Cadence decisions.
  localparam code_t CODE_DROP = 2'd0;
  localparam code_t CODE_NORMAL = 2'd1;
  localparam code_t CODE_REPEAT = 2'd2;

  // Register indexes on the configuration port.
  localparam int REG_OUTPUT_MODE = 0;

  // Balance limits before and after the first decision.
  localparam balance_t LIMIT_SEARCH = 4'sd3;
  localparam balance_t LIMIT_LOCKED = 4'sd5;

  typedef struct packed {
    logic       first_picture;
    logic [1:0] field_flags;
  } in_item_t;

  typedef struct packed {
    code_t      repeat_code;
    emit_t      frames_emitted;
    out_count_t frames_total;
    out_count_t film_purity_count;
    out_count_t ntsc_purity_count;
  } out_item_t;

  // One picture handed to the processing units, with the mode in force.
  typedef struct packed {
    logic       first;
    logic [1:0] flags;
    mode_t      mode;
  } step_t;

  // Decision and purity counters from the cadence detector.
  typedef struct packed {
    code_t  code;
    count_t film;
    count_t ntsc;
  } cadence_res_t;

  // Saturating add of a small increment to a counter.
  function automatic count_t sat_add(count_t v, emit_t n);
    logic [COUNT_BITS:0] s;
    s = {1'b0, v} + (COUNT_BITS + 1)'(n);
    if (s[COUNT_BITS]) begin
      return '1;
    end
    return s[COUNT_BITS-1:0];
  endfunction

  // Visible low bits of a counter.
  function automatic out_count_t to_out(count_t v);
    return OUT_COUNT_BITS'(v);
  endfunction

endpackage

// ===== hdl/pulldown_field_pairing_control.sv =====
// Top level: input register, cadence and pairing units, result register, register port.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid/in_ready    in_data (in_item_t)
//   out_      output     out_valid/out_ready  out_data (out_item_t)
//   register  APB write  psel/penable/pready  paddr, pwdata, prdata
//
// An accepted picture is held in the input register, is decided and
// paired by combinational logic, and its result is held in the output
// register; one picture per cycle is sustained while out_ready is high.
// Reset is synchronous and active low; it clears all cadence and field state
// and sets the output mode to normal. A stalled result register holds the
// input register, and the input takes a new transfer whenever its register
// empties or moves on in the same cycle.
module pulldown_field_pairing_control (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pfp_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pfp_pkg::out_item_t                out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pfp_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [pfp_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [pfp_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import pfp_pkg::*;

  mode_t        mode_r;
  logic         in_valid_r;
  in_item_t     in_r;
  logic         out_valid_r;
  out_item_t    out_r;
  logic         advance;
  logic         reg_sel;
  step_t        step;
  cadence_res_t cad;
  emit_t        emitted;
  count_t       frames;

  // Register port: one word-aligned register, always ready.
  assign pready = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_BITS-1:2] == (CFG_ADDR_BITS - 2)'(REG_OUTPUT_MODE));
  assign prdata = reg_sel ? CFG_DATA_BITS'(mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
    end else if (psel && penable && pwrite && reg_sel) begin
      mode_r <= pwdata[1:0];
    end
  end

  // Pipeline control: the picture in the input register moves on when the
  // result register is empty or its transfer completes.
  assign advance = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  assign step.first = in_r.first_picture;
  assign step.flags = in_r.field_flags;
  assign step.mode = mode_r;

  pfp_cadence u_cadence (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .step    (step),
    .res     (cad)
  );

  pfp_field_pair u_field_pair (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .step    (step),
    .code    (cad.code),
    .emitted (emitted),
    .frames  (frames)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.repeat_code <= cad.code;
      out_r.frames_emitted <= emitted;
      out_r.frames_total <= to_out(frames);
      out_r.film_purity_count <= to_out(cad.film);
      out_r.ntsc_purity_count <= to_out(cad.ntsc);
    end
  end

endmodule

// ===== hdl/pfp_cadence.sv =====
// Cadence detector: purity counters, signed repeat balance and lock.
module pfp_cadence (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  pfp_pkg::step_t       step,
  output pfp_pkg::cadence_res_t res
);
  import pfp_pkg::*;

  logic [1:0] last_flags_r, last_flags_nxt;
  balance_t   balance_r, balance_nxt;
  logic       locked_r, locked_nxt;
  count_t     film_r, film_nxt;
  count_t     ntsc_r, ntsc_nxt;

  balance_t   bal_base;
  balance_t   bal_step;
  balance_t   limit;
  logic       follows;
  code_t      code;

  // A first picture clears the detector before its own flags are seen.
  always_comb begin
    bal_base = step.first ? '0 : balance_r;
    bal_step = step.flags[0] ? bal_base + 4'sd1 : bal_base - 4'sd1;
    limit = (locked_r && !step.first) ? LIMIT_LOCKED : LIMIT_SEARCH;
    follows = (step.flags == 2'(last_flags_r + 2'd1));

    // Film and NTSC cadence purity; the first picture is not counted.
    film_nxt = step.first ? '0 : film_r;
    ntsc_nxt = step.first ? '0 : ntsc_r;
    if (!step.first) begin
      if (follows) begin
        film_nxt = sat_add(film_r, 3'd1);
      end else begin
        ntsc_nxt = sat_add(ntsc_r, 3'd1);
      end
    end

    // Balance limit check picks the decision.
    last_flags_nxt = step.flags;
    balance_nxt = bal_step;
    locked_nxt = step.first ? 1'b0 : locked_r;
    code = CODE_NORMAL;
    if (bal_step <= -limit) begin
      balance_nxt = '0;
      locked_nxt = 1'b1;
      code = CODE_DROP;
    end else if (bal_step >= limit) begin
      balance_nxt = '0;
      locked_nxt = 1'b1;
      code = CODE_REPEAT;
    end
  end

  assign res.code = code;
  assign res.film = film_nxt;
  assign res.ntsc = ntsc_nxt;

  // Detector state advances once per processed picture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_flags_r <= '0;
      balance_r <= '0;
      locked_r <= 1'b0;
      film_r <= '0;
      ntsc_r <= '0;
    end else if (step_en) begin
      last_flags_r <= last_flags_nxt;
      balance_r <= balance_nxt;
      locked_r <= locked_nxt;
      film_r <= film_nxt;
      ntsc_r <= ntsc_nxt;
    end
  end

endmodule

// ===== hdl/pfp_field_pair.sv =====
// Field-held flags, frame pairing and the running frame counter.
module pfp_field_pair (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  pfp_pkg::step_t  step,
  input  pfp_pkg::code_t  code,
  output pfp_pkg::emit_t  emitted,
  output pfp_pkg::count_t frames
);
  import pfp_pkg::*;

  typedef struct packed {
    logic       top;
    logic       bottom;
    logic [1:0] n;
  } store_t;

  // One store of a picture. The two fields always complete exactly one
  // frame and leave the held flags as they were; the optional extra field
  // then completes a frame only if the opposite field is held.
  function automatic store_t store(logic top, logic bottom, logic tff, logic extra);
    store_t s;
    s.top = top;
    s.bottom = bottom;
    s.n = 2'd1;
    if (extra) begin
      if (tff) begin
        if (bottom) begin
          s.bottom = 1'b0;
          s.n = 2'd2;
        end else begin
          s.top = 1'b1;
        end
      end else begin
        if (top) begin
          s.top = 1'b0;
          s.n = 2'd2;
        end else begin
          s.bottom = 1'b1;
        end
      end
    end
    return s;
  endfunction

  logic   top_r, top_nxt;
  logic   bottom_r, bottom_nxt;
  count_t frames_r, frames_nxt;

  logic   film, raw, extra, do_first, do_second;
  store_t s1, s2;
  logic   t0, b0;
  emit_t  n_total;

  always_comb begin
    film = (step.mode == MODE_FILM);
    raw = (step.mode == MODE_RAW);
    extra = !film && !raw && step.flags[0];
    do_first = !film || (code != CODE_DROP);
    do_second = !film && (code == CODE_REPEAT);
    t0 = step.first ? 1'b0 : top_r;
    b0 = step.first ? 1'b0 : bottom_r;

    // First store, then the repeat store from its result.
    s1 = store(t0, b0, step.flags[1], extra);
    if (!do_first) begin
      s1 = '{top: t0, bottom: b0, n: 2'd0};
    end
    s2 = store(s1.top, s1.bottom, step.flags[1], extra);
    if (!do_second) begin
      s2 = '{top: s1.top, bottom: s1.bottom, n: 2'd0};
    end

    n_total = emit_t'(s1.n) + emit_t'(s2.n);
    top_nxt = s2.top;
    bottom_nxt = s2.bottom;
    frames_nxt = sat_add(step.first ? '0 : frames_r, n_total);
  end

  assign emitted = n_total;
  assign frames = frames_nxt;

  // Held flags and frame count advance once per processed picture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= 1'b0;
      bottom_r <= 1'b0;
      frames_r <= '0;
    end else if (step_en) begin
      top_r <= top_nxt;
      bottom_r <= bottom_nxt;
      frames_r <= frames_nxt;
    end
  end

endmodule
